FILE: design/assert_macros.svh
// Assertion macros shared by the reply checker RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on the rising clock, quiet while reset is held.
`define ASSERT_CLK(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("reply checker assertion failed");

// Concurrent check that is also evaluated during reset.
`define ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk_i) (prop)) \
    else $error("reply checker assertion failed");

`endif

FILE: design/mbrc_pkg.sv
// Types, constants and the CRC byte update for the reply checker.
package mbrc_pkg;

  localparam logic [15:0] CRC_INIT   = 16'hFFFF;
  localparam logic [15:0] CRC_POLY   = 16'hA001;
  localparam logic [7:0]  BCAST_ADDR = 8'd253;
  localparam logic [7:0]  ADDR_RESET = 8'd1;
  localparam logic [3:0]  CRC_SPAN   = 4'd5;
  localparam logic [3:0]  POS_LAST   = 4'd6;   // position of the seventh byte
  localparam logic [3:0]  POS_ADDR   = 4'd0;
  localparam logic [3:0]  POS_VAL_HI = 4'd3;
  localparam logic [3:0]  POS_VAL_LO = 4'd4;
  localparam logic [3:0]  POS_CRC_LO = 4'd5;
  localparam logic [3:0]  COUNT_MAX  = 4'd15;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_LEN  = 2'd1,
    ST_ADDR = 2'd2,
    ST_CRC  = 2'd3
  } status_e;

  // One received byte with its end-of-reply mark
  typedef struct packed {
    logic [7:0] rx_byte;
    logic       is_last;
  } item_t;

  // One check result
  typedef struct packed {
    logic [15:0] register_value;
    status_e     status;
  } result_t;

  // Tracker state visible to the top level
  typedef struct packed {
    logic [3:0] byte_count;
  } track_stat_t;

  // Reflected CRC-16 over one byte, eight bit steps
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

FILE: design/mbrc_in_stage.sv
// Input register: holds one received item until the tracker takes it.
module mbrc_in_stage (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  mbrc_pkg::item_t in_item_i,
  output logic           valid_o,
  output mbrc_pkg::item_t item_o,
  input  logic           take_i
);
  import mbrc_pkg::*;

  logic  valid_q;
  item_t item_q;

  // Accept whenever the slot is empty or being drained this cycle
  assign in_ready_o = !valid_q || take_i;

  // Hold the valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  // Capture the payload
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      item_q <= in_item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

FILE: design/mbrc_track.sv
// Reply tracker: CRC, field capture and status decision per byte.
module mbrc_track (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  mbrc_pkg::item_t     item_i,
  input  logic [7:0]          slave_address_i,
  output mbrc_pkg::result_t   result_o,
  output mbrc_pkg::track_stat_t stat_o
);
  import mbrc_pkg::*;

  logic [15:0] crc_q, crc_d;
  logic [3:0]  count_q, count_d;
  logic [7:0]  addr_q, addr_d;
  logic [15:0] value_q, value_d;
  logic [7:0]  crc_lo_q, crc_lo_d;

  // Update the running state for the current byte
  always_comb begin
    crc_d    = crc_q;
    count_d  = count_q;
    addr_d   = addr_q;
    value_d  = value_q;
    crc_lo_d = crc_lo_q;
    if (count_q < CRC_SPAN) begin
      crc_d = crc_byte(crc_q, item_i.rx_byte);
    end
    case (count_q)
      POS_ADDR:   addr_d        = item_i.rx_byte;
      POS_VAL_HI: value_d[15:8] = item_i.rx_byte;
      POS_VAL_LO: value_d[7:0]  = item_i.rx_byte;
      POS_CRC_LO: crc_lo_d      = item_i.rx_byte;
      default: ;
    endcase
    if (item_i.is_last) begin
      // drop the reply state for the next one
      crc_d    = CRC_INIT;
      count_d  = '0;
      addr_d   = '0;
      value_d  = '0;
      crc_lo_d = '0;
    end else if (count_q < COUNT_MAX) begin
      count_d = count_q + 4'd1;
    end
  end

  // Decide the status; only meaningful on the last byte
  always_comb begin
    result_o.register_value = '0;
    if (count_q != POS_LAST) begin
      result_o.status = ST_LEN;
    end else if (slave_address_i != BCAST_ADDR && addr_q != slave_address_i) begin
      result_o.status = ST_ADDR;
    end else if ({item_i.rx_byte, crc_lo_q} != crc_q) begin
      result_o.status = ST_CRC;
    end else begin
      result_o.status         = ST_OK;
      result_o.register_value = value_q;
    end
  end

  // Advance the state on each byte taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q    <= CRC_INIT;
      count_q  <= '0;
      addr_q   <= '0;
      value_q  <= '0;
      crc_lo_q <= '0;
    end else if (step_i) begin
      crc_q    <= crc_d;
      count_q  <= count_d;
      addr_q   <= addr_d;
      value_q  <= value_d;
      crc_lo_q <= crc_lo_d;
    end
  end

  assign stat_o.byte_count = count_q;

endmodule

FILE: design/mbrc_out_stage.sv
// Result register on the output stream.
module mbrc_out_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  mbrc_pkg::result_t result_i,
  output logic              free_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output mbrc_pkg::result_t result_o
);
  import mbrc_pkg::*;

  logic    valid_q;
  result_t result_q;

  // The slot can take a new result if empty or emptied this cycle
  assign free_o = !valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  // Hold the result until taken
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      result_q <= result_i;
    end
  end

  assign out_valid_o = valid_q;
  assign result_o    = result_q;

endmodule

FILE: design/modbus_rtu_reply_checker.sv
// A last byte's result is offered from the result register, loaded as the byte leaves the input register.
// Throughput: one byte per cycle unless a last byte waits on a stalled result; the input
// register, the tracker update (unrolled CRC byte step) and the result register each hold one item.
// A stalled result holds a following last byte in the input register, and the input waits behind it.
// Reset (rst_ni low, asynchronous): both stages empty, reply state cleared,
// slave address back to 1.
`include "assert_macros.svh"

module modbus_rtu_reply_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,     // slave_address
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,    // [7:0] rx_byte
  input  logic        s_axis_tlast,    // is_last
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata     // [1:0] status, [17:2] register_value, zero pad
);
  import mbrc_pkg::*;

  logic [7:0]  slave_address_q;
  item_t       in_item, stage_item;
  logic        stage_valid;
  logic        out_free;
  logic        step;
  logic        load;
  result_t     track_result, out_result;
  track_stat_t track_stat;

  // Hold the configured slave address
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slave_address_q <= ADDR_RESET;
    end else if (cfg_we_i) begin
      slave_address_q <= cfg_wdata_i;
    end
  end

  assign in_item.rx_byte = s_axis_tdata;
  assign in_item.is_last = s_axis_tlast;

  // A byte moves on unless it ends a reply and the result slot is full
  assign step = stage_valid && (!stage_item.is_last || out_free);
  assign load = step && stage_item.is_last;

  mbrc_in_stage u_in (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_item_i  (in_item),
    .valid_o    (stage_valid),
    .item_o     (stage_item),
    .take_i     (step)
  );

  mbrc_track u_track (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .step_i          (step),
    .item_i          (stage_item),
    .slave_address_i (slave_address_q),
    .result_o        (track_result),
    .stat_o          (track_stat)
  );

  mbrc_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (load),
    .result_i    (track_result),
    .free_o      (out_free),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .result_o    (out_result)
  );

  assign m_axis_tdata = {6'b000000, out_result.register_value, out_result.status};

  // A finished reply always leaves a result behind
  `ASSERT_CLK(a_load_gives_result, load |=> m_axis_tvalid)
  // The reply state restarts after the last byte
  `ASSERT_CLK(a_count_cleared, load |=> (track_stat.byte_count == 4'd0))
  // A non-OK status never carries a value
  `ASSERT_CLK(a_value_only_ok,
              (m_axis_tvalid && out_result.status != ST_OK) |->
              (out_result.register_value == 16'd0))
  // Input back-pressure only when the input register is occupied
  `ASSERT_ALWAYS(a_ready_when_empty, !stage_valid |-> s_axis_tready)

endmodule
